>>> src/motor_feedback_tracker_defines.svh
// Assertion macros used by the checker module of the motor feedback tracker.
`ifndef MOTOR_FEEDBACK_TRACKER_DEFINES_SVH
`define MOTOR_FEEDBACK_TRACKER_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define MFT_ASSERT_SAME(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("motor feedback tracker: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define MFT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("motor feedback tracker: next-cycle check failed");

`endif

>>> src/mft_pkg.sv
`default_nettype none

package mft_pkg;

  localparam logic [15:0]        SilenceLimitReset = 16'd100;
  localparam logic [15:0]        WrapThreshold     = 16'd4095;
  localparam logic signed [31:0] WrapSpan          = 32'sd8191;

  // Register select taken from paddr bit 2 (registers sit four bytes apart).
  localparam logic CfgSilenceLimit = 1'b0;

  typedef enum logic {
    KindFrame = 1'b0,
    KindTick  = 1'b1
  } kind_e;

  typedef struct packed {
    kind_e      kind;
    logic [7:0] angle_high_byte;
    logic [7:0] angle_low_byte;
    logic [7:0] speed_high_byte;
    logic [7:0] speed_low_byte;
    logic [7:0] current_high_byte;
    logic [7:0] current_low_byte;
    logic [7:0] temperature_byte;
  } in_item_t;

  typedef struct packed {
    logic [15:0]        angle;
    logic signed [15:0] speed;
    logic signed [15:0] current;
    logic [7:0]         temperature;
    logic signed [31:0] turn_total;
    logic               online;
  } out_item_t;

  typedef struct packed {
    logic               frame_seen;
    logic [15:0]        prev_angle;
    logic signed [31:0] turn_total;
  } unwrap_state_t;

endpackage

`default_nettype wire

>>> src/mft_unwrap.sv
`default_nettype none

module mft_unwrap
  import mft_pkg::*;
(
  input  unwrap_state_t      state_i,
  input  logic [15:0]        angle_i,
  output logic signed [31:0] turn_total_o
);

  logic [15:0]        raw;
  logic [16:0]        mag;
  logic signed [31:0] diff;
  logic signed [31:0] adj;

  always_comb begin
    raw  = angle_i - state_i.prev_angle;
    mag  = raw[15] ? (17'h10000 - {1'b0, raw}) : {1'b0, raw};
    diff = signed'({{16{raw[15]}}, raw});
    adj  = '0;
    if (mag > {1'b0, WrapThreshold}) begin
      adj = raw[15] ? WrapSpan : -WrapSpan;
    end
    if (state_i.frame_seen) begin
      turn_total_o = state_i.turn_total + diff + adj;
    end else begin
      turn_total_o = state_i.turn_total;
    end
  end

endmodule

`default_nettype wire

>>> src/motor_feedback_tracker.sv
// Motor feedback tracker.
// Items enter on the in channel (in_valid_i, in_ready_o, in_item_i): either a
// seven-byte feedback frame or a time tick. Every item gives exactly one result
// on the out channel (out_valid_o, out_ready_i, out_item_o) carrying the held
// angle, speed, current, temperature, the unwrapped turn total and the status.
// An item passes an input register and then updates the tracking state, which
// is the result register. One item is taken every cycle while the receiver
// takes results; the rate is set by the single update of the add and compare
// logic between the two registers.
// When the receiver stalls, the result and the state hold; one more item may
// enter the input register, after which in_ready_o falls until the result is
// taken. Reset empties both stages, clears all held values and the turn total,
// marks the motor offline and sets the silence limit to 100 ticks.
// The silence limit is written over the APB port at byte address 0; pready is
// always high. The user must write it only while idle; nothing enforces this.
`default_nettype none

module motor_feedback_tracker
  import mft_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  in_item_t    in_item_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output out_item_t   out_item_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic     stg_vld_q;
  in_item_t stg_item_q;
  logic     out_vld_q;
  logic     advance;

  logic               frame_seen_q, frame_seen_d;
  logic [15:0]        prev_angle_q, prev_angle_d;
  logic signed [31:0] turn_total_q, turn_total_d;
  logic [15:0]        silence_q, silence_d;
  logic               online_q, online_d;
  logic signed [15:0] speed_q, speed_d;
  logic signed [15:0] current_q, current_d;
  logic [7:0]         temp_q, temp_d;
  logic [15:0]        limit_q;

  logic [15:0]        frame_angle;
  logic signed [31:0] unwrapped_total;
  logic [16:0]        silence_inc;
  unwrap_state_t      unwrap_state;

  assign advance    = !out_vld_q || out_ready_i;
  assign in_ready_o = !stg_vld_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stg_vld_q <= 1'b0;
    end else if (in_ready_o) begin
      stg_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      stg_item_q <= in_item_i;
    end
  end

  assign frame_angle = {stg_item_q.angle_high_byte, stg_item_q.angle_low_byte};

  assign unwrap_state = '{frame_seen: frame_seen_q,
                          prev_angle: prev_angle_q,
                          turn_total: turn_total_q};

  mft_unwrap u_unwrap (
    .state_i      (unwrap_state),
    .angle_i      (frame_angle),
    .turn_total_o (unwrapped_total)
  );

  assign silence_inc = {1'b0, silence_q} + 17'd1;

  always_comb begin
    frame_seen_d = frame_seen_q;
    prev_angle_d = prev_angle_q;
    turn_total_d = turn_total_q;
    silence_d    = silence_q;
    online_d     = online_q;
    speed_d      = speed_q;
    current_d    = current_q;
    temp_d       = temp_q;
    unique case (stg_item_q.kind)
      KindFrame: begin
        frame_seen_d = 1'b1;
        prev_angle_d = frame_angle;
        turn_total_d = unwrapped_total;
        silence_d    = '0;
        speed_d      = signed'({stg_item_q.speed_high_byte, stg_item_q.speed_low_byte});
        current_d    = signed'({stg_item_q.current_high_byte,
                                stg_item_q.current_low_byte});
        temp_d       = stg_item_q.temperature_byte;
      end
      KindTick: begin
        if (silence_inc > {1'b0, limit_q}) begin
          silence_d = limit_q;
          online_d  = 1'b0;
        end else begin
          silence_d = silence_inc[15:0];
          online_d  = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q    <= 1'b0;
      frame_seen_q <= 1'b0;
      prev_angle_q <= '0;
      turn_total_q <= '0;
      silence_q    <= '0;
      online_q     <= 1'b0;
      speed_q      <= '0;
      current_q    <= '0;
      temp_q       <= '0;
    end else if (advance) begin
      out_vld_q <= stg_vld_q;
      if (stg_vld_q) begin
        frame_seen_q <= frame_seen_d;
        prev_angle_q <= prev_angle_d;
        turn_total_q <= turn_total_d;
        silence_q    <= silence_d;
        online_q     <= online_d;
        speed_q      <= speed_d;
        current_q    <= current_d;
        temp_q       <= temp_d;
      end
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_item_o  = '{angle:       prev_angle_q,
                         speed:       speed_q,
                         current:     current_q,
                         temperature: temp_q,
                         turn_total:  turn_total_q,
                         online:      online_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= SilenceLimitReset;
    end else if (psel && penable && pwrite && pready && (paddr[2] == CfgSilenceLimit)) begin
      limit_q <= pwdata[15:0];
    end
  end

  assign pready = 1'b1;
  assign prdata = (paddr[2] == CfgSilenceLimit) ? {16'd0, limit_q} : 32'd0;

endmodule

`default_nettype wire

>>> src/mft_checker.sv
`default_nettype none
`include "motor_feedback_tracker_defines.svh"

module mft_checker
  import mft_pkg::*;
(
  input logic      clk_i,
  input logic      rst_ni,
  input logic      in_valid_i,
  input logic      in_ready_o,
  input logic      out_valid_o,
  input logic      out_ready_i,
  input out_item_t out_item_o
);

  logic out_stall;
  logic in_xfer;

  assign out_stall = out_valid_o && !out_ready_i;
  assign in_xfer   = in_valid_i && in_ready_o;

  `MFT_ASSERT_NEXT(a_out_valid_held, clk_i, rst_ni, out_stall, out_valid_o)
  `MFT_ASSERT_NEXT(a_out_item_held, clk_i, rst_ni, out_stall, $stable(out_item_o))
  `MFT_ASSERT_SAME(a_in_ready_only_low_on_stall, clk_i, rst_ni, !in_ready_o, out_stall)
  `MFT_ASSERT_SAME(a_result_follows_transfer, clk_i, rst_ni, $rose(out_valid_o), $past(in_xfer, 2))

endmodule

bind motor_feedback_tracker mft_checker u_mft_checker (.*);

`default_nettype wire

>>> tb/sv/mft_feedback_check.sv
`default_nettype none

module mft_feedback_check
  import mft_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  in_item_t    in_item_i,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  out_item_t   out_item_i,
  input  logic        psel_i,
  input  logic        penable_i,
  input  logic        pwrite_i,
  input  logic [2:0]  paddr_i,
  input  logic [31:0] pwdata_i,
  input  logic        pready_i,
  output int unsigned fault_count_o,
  output int unsigned pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [15:0]        UnwrapThreshold = 16'd4095;
  localparam logic signed [31:0] UnwrapSpan      = 32'sd8191;
  localparam logic [15:0]        QuietLimitReset = 16'd100;

  logic [15:0]        last_angle;
  logic signed [31:0] turn_sum;
  logic               had_frame;
  logic [15:0]        quiet_ticks;
  logic               is_online;
  logic [15:0]        speed_q;
  logic [15:0]        current_q;
  logic [7:0]         temp_q;
  logic [15:0]        quiet_limit;

  out_item_t   pending_readings[$];
  out_item_t   want;
  int unsigned faults;

  task automatic report_fault(input string what);
    faults++;
    $display("mismatch at %0t: %s", $realtime, what);
  endtask

  function automatic out_item_t track_item(input in_item_t item);
    logic [15:0]        angle_now;
    logic [15:0]        step16;
    logic [15:0]        mag;
    logic signed [31:0] step;
    logic [16:0]        next_ticks;
    out_item_t          reading;
    if (item.kind == KindFrame) begin
      angle_now = {item.angle_high_byte, item.angle_low_byte};
      step = '0;
      if (had_frame) begin
        step16 = angle_now - last_angle;
        step = {{16{step16[15]}}, step16};
        mag = step16[15] ? (~step16 + 16'd1) : step16;
        if (mag > UnwrapThreshold) begin
          step = step16[15] ? step + UnwrapSpan : step - UnwrapSpan;
        end
      end
      turn_sum = turn_sum + step;
      last_angle = angle_now;
      had_frame = 1'b1;
      speed_q = {item.speed_high_byte, item.speed_low_byte};
      current_q = {item.current_high_byte, item.current_low_byte};
      temp_q = item.temperature_byte;
      quiet_ticks = '0;
    end else begin
      next_ticks = {1'b0, quiet_ticks} + 17'd1;
      if (next_ticks > {1'b0, quiet_limit}) begin
        quiet_ticks = quiet_limit;
        is_online = 1'b0;
      end else begin
        quiet_ticks = next_ticks[15:0];
        is_online = 1'b1;
      end
    end
    reading.angle = last_angle;
    reading.speed = speed_q;
    reading.current = current_q;
    reading.temperature = temp_q;
    reading.turn_total = turn_sum;
    reading.online = is_online;
    return reading;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_angle = '0;
      turn_sum = '0;
      had_frame = 1'b0;
      quiet_ticks = '0;
      is_online = 1'b0;
      speed_q = '0;
      current_q = '0;
      temp_q = '0;
      quiet_limit = QuietLimitReset;
      pending_readings.delete();
      faults = 0;
      fault_count_o <= 0;
      pending_o <= 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (pending_readings.size() == 0) begin
          report_fault("result transfer with no reading pending");
        end else begin
          want = pending_readings.pop_front();
          if (out_item_i.angle !== want.angle) begin
            report_fault($sformatf("angle %h, expected %h", out_item_i.angle, want.angle));
          end
          if (out_item_i.speed !== want.speed) begin
            report_fault($sformatf("speed %h, expected %h", out_item_i.speed, want.speed));
          end
          if (out_item_i.current !== want.current) begin
            report_fault($sformatf("current %h, expected %h",
                                   out_item_i.current, want.current));
          end
          if (out_item_i.temperature !== want.temperature) begin
            report_fault($sformatf("temperature %h, expected %h",
                                   out_item_i.temperature, want.temperature));
          end
          if (out_item_i.turn_total !== want.turn_total) begin
            report_fault($sformatf("turn total %h, expected %h",
                                   out_item_i.turn_total, want.turn_total));
          end
          if (out_item_i.online !== want.online) begin
            report_fault($sformatf("online %b, expected %b", out_item_i.online, want.online));
          end
        end
      end
      if (psel_i && penable_i && pwrite_i && pready_i && paddr_i[2] == CfgSilenceLimit) begin
        quiet_limit = pwdata_i[15:0];
      end
      if (in_valid_i && in_ready_i) begin
        pending_readings.push_back(track_item(in_item_i));
      end
      fault_count_o <= faults;
      pending_o <= pending_readings.size();
    end
  end

endmodule

`default_nettype wire

>>> tb/sv/testbench.sv
`default_nettype none

module testbench;
  import mft_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned WatchdogLimit = 4000;
  localparam int unsigned PhaseItems    = 100;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  in_item_t    in_item;
  logic        out_valid;
  logic        out_ready;
  out_item_t   out_item;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;
  int unsigned faults;
  int unsigned pending;

  int unsigned send_gap_pct;
  int unsigned take_gap_pct;
  int unsigned stall_left = 0;
  int unsigned quiet_cycles = 0;
  logic [15:0] angle_walk;

  motor_feedback_tracker dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_item_i  (in_item),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_item_o (out_item),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  mft_feedback_check u_check (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_ready_i   (in_ready),
    .in_item_i    (in_item),
    .out_valid_i  (out_valid),
    .out_ready_i  (out_ready),
    .out_item_i   (out_item),
    .psel_i       (psel),
    .penable_i    (penable),
    .pwrite_i     (pwrite),
    .paddr_i      (paddr),
    .pwdata_i     (pwdata),
    .pready_i     (pready),
    .fault_count_o(faults),
    .pending_o    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic in_item_t make_frame(input logic [15:0] angle, input logic [15:0] speed,
                                          input logic [15:0] current, input logic [7:0] temp);
    in_item_t item;
    item.kind = KindFrame;
    {item.angle_high_byte, item.angle_low_byte} = angle;
    {item.speed_high_byte, item.speed_low_byte} = speed;
    {item.current_high_byte, item.current_low_byte} = current;
    item.temperature_byte = temp;
    return item;
  endfunction

  function automatic in_item_t random_frame(input logic [15:0] angle);
    return make_frame(angle, 16'($urandom), 16'($urandom), 8'($urandom));
  endfunction

  // The byte fields of a tick carry noise, since the block ignores them.
  function automatic in_item_t tick_item();
    logic [63:0] noise;
    in_item_t    item;
    noise = {$urandom, $urandom};
    item = noise[56:0];
    item.kind = KindTick;
    return item;
  endfunction

  function automatic logic [15:0] angle_step();
    logic [15:0] delta;
    case ($urandom_range(3))
      0: delta = 16'($urandom_range(0, 300));
      1: delta = 16'($urandom_range(4093, 4098));
      2: delta = 16'($urandom_range(8185, 8197));
      default: delta = 16'($urandom);
    endcase
    return $urandom_range(1) ? delta : -delta;
  endfunction

  task automatic send_item(input in_item_t item);
    if (send_gap_pct != 0 && $urandom_range(99) < send_gap_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_item <= item;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  task automatic write_limit(input logic [15:0] value);
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (4) @(negedge clk);
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= {CfgSilenceLimit, 2'b00};
    pwdata <= {16'd0, value};
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (stall_left != 0) begin
        out_ready <= 1'b0;
        stall_left--;
      end else if (take_gap_pct != 0 && $urandom_range(99) < take_gap_pct) begin
        stall_left = $urandom_range(0, 7);
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles == WatchdogLimit) begin
      $display("testbench: done, errors");
      $finish;
    end
  end

  initial begin
    int unsigned sent;
    int unsigned run;
    logic [15:0] limit;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_item = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    send_gap_pct = 20;
    take_gap_pct = 20;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // A tick before any frame, then the first frame, which adds nothing to the total.
    send_item(tick_item());
    send_item(make_frame(16'h1234, 16'h8000, 16'h7FFF, 8'hFF));
    send_item(make_frame(16'h2233, 16'h7FFF, 16'h8000, 8'h00));
    send_item(make_frame(16'h3233, 16'h0000, 16'h0000, 8'h00));
    send_item(make_frame(16'h2234, 16'hFFFF, 16'hFFFF, 8'hFF));
    send_item(make_frame(16'h1234, 16'h0001, 16'hFFFE, 8'h80));
    send_item(make_frame(16'h9234, 16'h8001, 16'h7FFE, 8'h7F));
    send_item(random_frame(16'hFFFF));
    send_item(random_frame(16'h0000));
    send_item(random_frame(16'h0000));
    send_item(random_frame(16'hFFF0));

    // A limit of zero keeps the counter at zero and the motor offline.
    write_limit(16'd0);
    send_item(tick_item());
    send_item(tick_item());
    write_limit(16'd2);
    repeat (3) send_item(tick_item());
    send_item(random_frame(16'hFFF8));
    send_item(tick_item());

    // Lowering the limit below the count clamps the count on the next tick.
    write_limit(16'd5);
    repeat (4) send_item(tick_item());
    write_limit(16'd1);
    send_item(tick_item());

    angle_walk = 16'hFFF0;

    for (int unsigned phase = 0; phase < 6; phase++) begin
      case (phase)
        0: limit = 16'd1;
        1: limit = 16'd3;
        2: limit = 16'hFFFF;
        3: limit = 16'($urandom_range(1, 40));
        4: limit = 16'd12;
        default: limit = 16'd100;
      endcase
      write_limit(limit);
      if (phase == 5) begin
        send_gap_pct = 0;
        take_gap_pct = 0;
      end else begin
        send_gap_pct = $urandom_range(2) * 15;
        take_gap_pct = $urandom_range(2) * 15;
      end
      sent = 0;
      while (sent < PhaseItems) begin
        run = $urandom_range(99);
        if (run < 45) begin
          angle_walk = angle_walk + angle_step();
          send_item(random_frame(angle_walk));
          sent++;
        end else if (run < 55) begin
          angle_walk = 16'($urandom);
          send_item(random_frame(angle_walk));
          sent++;
        end else begin
          run = ($urandom_range(9) == 0) ? $urandom_range(1, 30) : $urandom_range(1, 8);
          repeat (run) send_item(tick_item());
          sent += run;
        end
      end
    end

    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (8) @(negedge clk);
    if (faults == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

endmodule

`default_nettype wire
